/* src/dsb_pkg.sv */
package dsb_pkg;

  localparam int MAX_MICS    = 64;
  localparam int DELAY_DEPTH = 1024;
  localparam int SAMPLE_BITS = 24;

  localparam int MIC_BITS    = $clog2(MAX_MICS);
  localparam int COUNT_BITS  = $clog2(MAX_MICS + 1);
  localparam int DEPTH_BITS  = $clog2(DELAY_DEPTH);
  localparam int STORE_DEPTH = MAX_MICS * DELAY_DEPTH;
  localparam int STORE_BITS  = MIC_BITS + DEPTH_BITS;
  localparam int ACC_BITS    = SAMPLE_BITS + 6;

  localparam int STEP_BITS   = 16;
  localparam int GAIN_BITS   = 16;
  localparam int CFG_BITS    = 16;
  localparam int CFG_ADDR_BITS = 2;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_BITS-1:0] CFG_MIC_COUNT   = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_DELAY_STEP  = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_OUTPUT_GAIN = 2'd2;

  localparam logic [COUNT_BITS-1:0] MIC_COUNT_RESET   = COUNT_BITS'(2);
  localparam logic [GAIN_BITS-1:0]  OUTPUT_GAIN_RESET = GAIN_BITS'(32768);

  // Per-sample tap decision made from the mic index and the steering setup.
  typedef struct packed {
    logic                  keep;   // mic index lies inside the active array
    logic                  last;   // this mic closes the frame
    logic [DEPTH_BITS-1:0] delay;  // tap delay in samples, saturated
  } tap_t;

endpackage

/* src/dsb_ram.sv */
module dsb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data is registered and holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/dsb_delay_calc.sv */
module dsb_delay_calc (
  input  logic [dsb_pkg::COUNT_BITS-1:0]  mic_count,
  input  logic signed [dsb_pkg::STEP_BITS-1:0] delay_step,
  input  logic [dsb_pkg::MIC_BITS-1:0]    mic_index,
  output dsb_pkg::tap_t                   tap
);

  localparam int PROD_BITS = dsb_pkg::MIC_BITS + dsb_pkg::STEP_BITS;
  localparam int RND_BITS  = PROD_BITS + 1;

  logic [dsb_pkg::COUNT_BITS-1:0] count;
  logic [dsb_pkg::COUNT_BITS-1:0] index_ext;
  logic                           step_neg;
  logic [dsb_pkg::STEP_BITS-1:0]  mag;
  logic [dsb_pkg::MIC_BITS-1:0]   pos;
  logic [PROD_BITS-1:0]           prod;
  logic [RND_BITS-1:0]            rnd;
  logic [RND_BITS-9:0]            whole;

  always_comb begin
    // Clamp the array size to what the store can hold.
    if (mic_count < dsb_pkg::COUNT_BITS'(2)) begin
      count = dsb_pkg::COUNT_BITS'(2);
    end else if (mic_count > dsb_pkg::COUNT_BITS'(dsb_pkg::MAX_MICS)) begin
      count = dsb_pkg::COUNT_BITS'(dsb_pkg::MAX_MICS);
    end else begin
      count = mic_count;
    end

    index_ext = dsb_pkg::COUNT_BITS'(mic_index);
    step_neg  = delay_step[dsb_pkg::STEP_BITS-1];
    // Negating the most negative step wraps to its magnitude as unsigned.
    mag = step_neg ? dsb_pkg::STEP_BITS'(-delay_step) : dsb_pkg::STEP_BITS'(delay_step);
    // A negative step steers the other way: the far end of the array gets no delay.
    pos = step_neg ? dsb_pkg::MIC_BITS'(count - dsb_pkg::COUNT_BITS'(1) - index_ext)
                   : mic_index;

    prod  = PROD_BITS'(pos) * PROD_BITS'(mag);
    rnd   = RND_BITS'(prod) + RND_BITS'(128);
    whole = rnd[RND_BITS-1:8];

    tap.keep = index_ext < count;
    tap.last = index_ext == (count - dsb_pkg::COUNT_BITS'(1));
    if (whole > (RND_BITS-8)'(dsb_pkg::DELAY_DEPTH - 1)) begin
      tap.delay = dsb_pkg::DEPTH_BITS'(dsb_pkg::DELAY_DEPTH - 1);
    end else begin
      tap.delay = dsb_pkg::DEPTH_BITS'(whole);
    end
  end

endmodule

/* src/delay_and_sum_beamformer.sv */
// Channel  Direction  Content (lowest bit first)               Handshake
// in_      slave      tdata: mic_index[5:0], mic_sample[29:6]  tvalid/tready
// out_     master     tdata: beam_sample[23:0]                 tvalid/tready
// cfg_     write      addr 0 mic_count, 1 delay_step, 2 gain   cfg_we, no wait
//
// One word is taken per cycle while in_tready is high, a rate set by the single
// dual-port delay store (one write and one registered read each cycle). Once the
// word of the frame's last mic is accepted, its beam sample passes the s1, s2, s3,
// s4 and output registers. After reset the delay store is swept to zero, one entry
// a cycle, through 65536 entries; in_tready stays low meanwhile, cfg writes are taken.
// A stalled output holds the result register; bubbles inside the pipeline
// still close up, so input keeps flowing until every stage is full.
module delay_and_sum_beamformer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [5:0] mic_index, [29:6] mic_sample, [31:30] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [23:0] beam_sample
  input  logic        cfg_we,
  input  logic [dsb_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [dsb_pkg::CFG_BITS-1:0]      cfg_wdata
);

  localparam int SB   = dsb_pkg::SAMPLE_BITS;
  localparam int AB   = dsb_pkg::ACC_BITS;
  localparam int MB   = dsb_pkg::MIC_BITS;
  localparam int DB   = dsb_pkg::DEPTH_BITS;
  localparam int PB   = AB + dsb_pkg::GAIN_BITS + 2;
  localparam int SHB  = PB - 16;

  // Configuration registers.
  logic [dsb_pkg::COUNT_BITS-1:0]        mic_count_r;
  logic signed [dsb_pkg::STEP_BITS-1:0]  delay_step_r;
  logic [dsb_pkg::GAIN_BITS-1:0]         output_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mic_count_r   <= dsb_pkg::MIC_COUNT_RESET;
      delay_step_r  <= '0;
      output_gain_r <= dsb_pkg::OUTPUT_GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dsb_pkg::CFG_MIC_COUNT:   mic_count_r   <= dsb_pkg::COUNT_BITS'(cfg_wdata);
        dsb_pkg::CFG_DELAY_STEP:  delay_step_r  <= dsb_pkg::STEP_BITS'(cfg_wdata);
        dsb_pkg::CFG_OUTPUT_GAIN: output_gain_r <= dsb_pkg::GAIN_BITS'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Pipeline registers.
  logic                 clearing_r;
  logic [dsb_pkg::STORE_BITS-1:0] clr_addr_r;
  logic [DB-1:0]        wp_r;

  logic                 s1_v_r;
  logic [MB-1:0]        s1_mic_r;
  logic [SB-1:0]        s1_sample_r;

  logic                 s2_v_r;
  logic [MB-1:0]        s2_mic_r;
  logic [SB-1:0]        s2_sample_r;
  logic [DB-1:0]        s2_delay_r;
  logic                 s2_last_r;

  logic                 s3_v_r;
  logic [SB-1:0]        s3_sample_r;
  logic                 s3_bypass_r;
  logic                 s3_last_r;

  logic signed [AB-1:0] acc_r;
  logic signed [AB-1:0] acc_nxt;

  logic                 s4_v_r;
  logic signed [AB-1:0] s4_sum_r;

  logic                 out_valid_r;
  logic [SB-1:0]        out_data_r;

  // Flow control: each stage moves when the one after it is free or moving.
  logic out_free, s4_free, s3_done, s3_free, s2_free, s1_free;
  logic s2_go, s1_go, in_accept;

  dsb_pkg::tap_t s1_tap;

  assign out_free  = !out_valid_r || out_tready;
  assign s4_free   = !s4_v_r || out_free;
  // Frame-internal mics only feed the accumulator and never wait downstream.
  assign s3_done   = s3_v_r && (!s3_last_r || s4_free);
  assign s3_free   = !s3_v_r || s3_done;
  assign s2_go     = s2_v_r && s3_free;
  assign s2_free   = !s2_v_r || s3_free;
  assign s1_go     = s1_v_r && s2_free;
  assign s1_free   = !s1_v_r || s2_free;
  assign in_tready = !clearing_r && s1_free;
  assign in_accept = in_tvalid && in_tready;

  dsb_delay_calc u_delay_calc (
    .mic_count  (mic_count_r),
    .delay_step (delay_step_r),
    .mic_index  (s1_mic_r),
    .tap        (s1_tap)
  );

  // Delay store: line k occupies the entries with k in the upper address bits.
  logic                           ram_we;
  logic                           ram_re;
  logic [dsb_pkg::STORE_BITS-1:0] ram_waddr;
  logic [dsb_pkg::STORE_BITS-1:0] ram_raddr;
  logic [SB-1:0]                  ram_wdata;
  logic [SB-1:0]                  ram_rdata;
  logic [DB-1:0]                  rd_ptr;

  assign rd_ptr    = wp_r - s2_delay_r;
  assign ram_we    = clearing_r || s2_go;
  assign ram_waddr = clearing_r ? clr_addr_r : {s2_mic_r, wp_r};
  assign ram_wdata = clearing_r ? '0 : s2_sample_r;
  assign ram_re    = s2_go;
  assign ram_raddr = {s2_mic_r, rd_ptr};

  dsb_ram #(
    .WIDTH (SB),
    .DEPTH (dsb_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Accumulate the delayed tap. A zero delay reads the entry being written in
  // the same cycle, so the current sample is taken straight from the pipeline.
  logic [SB-1:0]          tap_val;
  logic signed [AB:0]     sum_wide;
  logic signed [AB-1:0]   sum_sat;
  localparam logic signed [AB:0] ACC_MAX = (AB+1)'((64'sd1 <<< (AB-1)) - 1);
  localparam logic signed [AB:0] ACC_MIN = -ACC_MAX - (AB+1)'(1);

  always_comb begin
    tap_val  = s3_bypass_r ? s3_sample_r : ram_rdata;
    sum_wide = (AB+1)'(acc_r) + (AB+1)'(signed'(tap_val));
    if (sum_wide > ACC_MAX) begin
      sum_sat = AB'(ACC_MAX);
    end else if (sum_wide < ACC_MIN) begin
      sum_sat = AB'(ACC_MIN);
    end else begin
      sum_sat = AB'(sum_wide);
    end

    acc_nxt = acc_r;
    if (s3_done) begin
      acc_nxt = s3_last_r ? '0 : sum_sat;
    end
  end

  // Output scaling: sum * gain, round half up, saturate to the sample width.
  logic signed [PB-1:0]  prod;
  logic signed [SHB-1:0] scaled;
  logic [SB-1:0]         beam_nxt;
  localparam logic signed [SHB-1:0] OUT_MAX = SHB'((64'sd1 <<< (SB-1)) - 1);
  localparam logic signed [SHB-1:0] OUT_MIN = -OUT_MAX - SHB'(1);

  always_comb begin
    prod   = PB'(s4_sum_r) * PB'(signed'({1'b0, output_gain_r}));
    prod   = prod + PB'(32768);
    scaled = SHB'(prod >>> 16);
    if (scaled > OUT_MAX) begin
      beam_nxt = SB'(OUT_MAX);
    end else if (scaled < OUT_MIN) begin
      beam_nxt = SB'(OUT_MIN);
    end else begin
      beam_nxt = SB'(scaled);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      wp_r        <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          clearing_r <= 1'b0;
        end
      end

      if (s1_free) begin
        s1_v_r <= in_accept;
      end
      if (s2_free) begin
        s2_v_r <= s1_go && s1_tap.keep;
      end
      if (s3_free) begin
        s3_v_r <= s2_go;
      end
      if (s2_go && s2_last_r) begin
        wp_r <= wp_r + 1'b1;
      end

      acc_r <= acc_nxt;

      if (s4_free) begin
        s4_v_r <= s3_done && s3_last_r;
      end
      if (out_free) begin
        out_valid_r <= s4_v_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mic_r    <= in_tdata[MB-1:0];
      s1_sample_r <= in_tdata[MB+SB-1:MB];
    end
    if (s1_go) begin
      s2_mic_r    <= s1_mic_r;
      s2_sample_r <= s1_sample_r;
      s2_delay_r  <= s1_tap.delay;
      s2_last_r   <= s1_tap.last;
    end
    if (s2_go) begin
      s3_sample_r <= s2_sample_r;
      s3_bypass_r <= s2_delay_r == '0;
      s3_last_r   <= s2_last_r;
    end
    if (s3_done && s3_last_r) begin
      s4_sum_r <= sum_sat;
    end
    if (s4_v_r && out_free) begin
      out_data_r <= beam_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The sweep owns the store's write port, so no word may enter meanwhile.
  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_tready)
    else $error("input accepted during store clearing");

  // The write pointer only moves when a frame-closing sample hits the store.
  a_wp_moves_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    !(s2_go && s2_last_r) |=> $stable(wp_r))
    else $error("write pointer moved without a frame end");

  // A retired frame leaves a clean accumulator for the next one.
  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    s3_done && s3_last_r |=> acc_r == '0)
    else $error("accumulator not cleared after frame end");

  // A held result in the sum stage is never overwritten.
  a_sum_held: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r && !out_free |=> s4_v_r && $stable(s4_sum_r))
    else $error("pending frame sum lost");

endmodule
